// ===== rtl/tkml_pkg.sv =====
// Shared types and constants for the top-k minimum list.
`timescale 1ns / 1ps

package tkml_pkg;

  localparam logic [31:0] SENTINEL = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_PLACE,
    S_READ,
    S_RDOUT
  } state_t;

  typedef struct packed {
    logic [15:0] tag;
    logic        reversed;
    logic [7:0]  start2;
    logic [7:0]  start1;
    logic [7:0]  start0;
    logic [7:0]  na;
    logic [2:0]  ih;
  } payload_t;

  typedef struct packed {
    logic [31:0] score;
    payload_t    pay;
  } entry_t;

  // flags from the shared score comparator
  typedef struct packed {
    logic near;
    logic below;
  } cmp_flags_t;

  typedef struct packed {
    logic        accepted;
    logic        duplicate;
    logic [6:0]  rank;
    logic [31:0] threshold;
    entry_t      entry;
  } result_t;

endpackage

// ===== rtl/tkml_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module tkml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tkml_cmp.sv =====
// Shared score comparator: near-duplicate test and ordering test.
`timescale 1ns / 1ps

module tkml_cmp
  import tkml_pkg::*;
(
  input  logic [31:0] cand,
  input  logic [31:0] stored,
  input  logic [15:0] tol,
  output cmp_flags_t  flags
);

  logic [31:0] diff;

  always_comb begin
    flags.below = cand < stored;
    diff        = (cand > stored) ? (cand - stored) : (stored - cand);
    flags.near  = diff < {16'd0, tol};
  end

endmodule

// ===== rtl/top_k_min_list_insert.sv =====
// Top level of the top-k minimum list: sequencer, list RAM and result registers.
`timescale 1ns / 1ps

// Keeps the TOP_ENTRIES lowest Q16.16 scores in ascending order, one RAM row per rank
// holding score and payload. Commands are taken on start while busy is low:
//   insert  - dropped at once, with a result, if not below the threshold;
//             otherwise a full scan of all ranks through one comparator checks for
//             near-duplicates and finds the sorted place; a near-duplicate ends it with a
//             duplicate result, else rows below the place move down one rank a cycle
//             and the new row is written.
//   read    - one RAM read; out of range answers at once.
//   clear   - one row written per cycle.
//   opcode 3 reports only the threshold.
// Exactly one result per command: done is high for one cycle with the result fields,
// and the receiver cannot stall it. Busy stays high until the command is finished.
// After reset the list runs a clearing pass with busy high and no result;
// dup_tolerance resets to 1. The configuration channel (cfg_valid,
// cfg_ready, cfg_data) is always ready; write it only while the block is idle.
module top_k_min_list_insert
  import tkml_pkg::*;
#(
  parameter int TOP_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] score,
  input  logic [2:0]  ih_type,
  input  logic [7:0]  na_count,
  input  logic [7:0]  start0,
  input  logic [7:0]  start1,
  input  logic [7:0]  start2,
  input  logic        reversed,
  input  logic [15:0] payload_tag,
  input  logic [6:0]  read_rank,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic        accepted,
  output logic        duplicate,
  output logic [6:0]  rank,
  output logic [31:0] threshold,
  output logic [31:0] entry_score,
  output logic [2:0]  entry_ih,
  output logic [7:0]  entry_na,
  output logic [7:0]  entry_start0,
  output logic [7:0]  entry_start1,
  output logic [7:0]  entry_start2,
  output logic        entry_reversed,
  output logic [15:0] entry_tag
);

  localparam int AW = $clog2(TOP_ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(TOP_ENTRIES - 1);
  localparam logic [AW-1:0] ONE  = AW'(1);

  state_t state, state_next;

  logic [AW-1:0] cnt, cnt_next;
  logic          issue, issue_next;       // reads still to be issued
  logic          rd_vld, rd_vld_next;     // RAM output holds row rd_idx
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic          dup_found, dup_found_next;
  logic          pos_found, pos_found_next;
  logic [AW-1:0] pos, pos_next;
  logic          clr_report, clr_report_next;
  logic [31:0]   worst, worst_next;
  logic [15:0]   tol;
  logic [31:0]   score_l, score_l_next;
  payload_t      pay_l, pay_l_next;
  logic          done_next;
  result_t       res, res_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;
  cmp_flags_t    flags;

  logic [31:0]   rr_wide;
  logic          rr_in_range;
  logic [31:0]   pos_wide;
  logic          scan_last, shift_last, clr_last;

  tkml_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TOP_ENTRIES)
  ) u_list_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tkml_cmp u_cmp (
    .cand  (score_l),
    .stored(ram_rdata.score),
    .tol   (tol),
    .flags (flags)
  );

  assign rr_wide     = {25'd0, read_rank};
  assign rr_in_range = rr_wide < 32'(TOP_ENTRIES);
  assign pos_wide    = 32'(pos);
  assign scan_last   = rd_vld && (rd_idx == LAST);
  assign shift_last  = rd_vld && (rd_idx == pos);
  assign clr_last    = cnt == LAST;

  assign busy      = state != S_IDLE;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_INSERT: if (score < worst) state_next = S_SCAN;
            OP_READ:   if (rr_in_range) state_next = S_READ;
            OP_CLEAR:  state_next = S_CLEAR;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN:   if (scan_last) state_next = S_DECIDE;
      S_DECIDE: begin
        if (dup_found) state_next = S_IDLE;
        else if (pos == LAST) state_next = S_PLACE;
        else state_next = S_SHIFT;
      end
      S_SHIFT:  if (shift_last) state_next = S_PLACE;
      S_PLACE:  state_next = S_IDLE;
      S_READ:   state_next = S_RDOUT;
      S_RDOUT:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath, RAM control and results
  always_comb begin
    cnt_next        = cnt;
    issue_next      = issue;
    rd_vld_next     = 1'b0;
    rd_idx_next     = rd_idx;
    dup_found_next  = dup_found;
    pos_found_next  = pos_found;
    pos_next        = pos;
    clr_report_next = clr_report;
    worst_next      = worst;
    score_l_next    = score_l;
    pay_l_next      = pay_l;
    done_next       = 1'b0;
    res_next        = res;
    ram_we          = 1'b0;
    ram_waddr       = cnt;
    ram_wdata       = ram_rdata;
    ram_raddr       = cnt;

    case (state)
      S_CLEAR: begin
        ram_we          = 1'b1;
        ram_wdata       = '0;
        ram_wdata.score = SENTINEL;
        cnt_next        = cnt + ONE;
        if (clr_last) begin
          done_next       = clr_report;
          res_next        = '0;
          clr_report_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (start) begin
          score_l_next = score;
          pay_l_next   = '{tag: payload_tag, reversed: reversed, start2: start2,
                           start1: start1, start0: start0, na: na_count, ih: ih_type};
          case (opcode)
            OP_INSERT: begin
              if (score < worst) begin
                cnt_next       = '0;
                issue_next     = 1'b1;
                dup_found_next = 1'b0;
                pos_found_next = 1'b0;
              end else begin
                done_next = 1'b1;
                res_next  = '0;
              end
            end
            OP_READ: begin
              if (rr_in_range) begin
                cnt_next = rr_wide[AW-1:0];
              end else begin
                done_next = 1'b1;
                res_next  = '0;
              end
            end
            OP_CLEAR: begin
              cnt_next        = '0;
              clr_report_next = 1'b1;
              worst_next      = SENTINEL;
            end
            default: begin
              done_next = 1'b1;
              res_next  = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_vld_next = issue;
        rd_idx_next = cnt;
        if (issue) begin
          if (cnt == LAST) issue_next = 1'b0;
          else cnt_next = cnt + ONE;
        end
        if (rd_vld) begin
          if (flags.near) dup_found_next = 1'b1;
          if (flags.below && !pos_found) begin
            pos_found_next = 1'b1;
            pos_next       = rd_idx;
          end
        end
      end
      S_DECIDE: begin
        if (dup_found) begin
          done_next          = 1'b1;
          res_next           = '0;
          res_next.duplicate = 1'b1;
        end else if (pos != LAST) begin
          cnt_next   = LAST - ONE;
          issue_next = 1'b1;
        end
      end
      S_SHIFT: begin
        // read rank cnt, write the row read last cycle one rank further down
        rd_vld_next = issue;
        rd_idx_next = cnt;
        if (issue) begin
          if (cnt == pos) issue_next = 1'b0;
          else cnt_next = cnt - ONE;
        end
        if (rd_vld) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx + ONE;
          ram_wdata = ram_rdata;
          if ((rd_idx + ONE) == LAST) worst_next = ram_rdata.score;
        end
      end
      S_PLACE: begin
        ram_we          = 1'b1;
        ram_waddr       = pos;
        ram_wdata.score = score_l;
        ram_wdata.pay   = pay_l;
        if (pos == LAST) worst_next = score_l;
        done_next         = 1'b1;
        res_next          = '0;
        res_next.accepted = 1'b1;
        res_next.rank     = pos_wide[6:0];
      end
      S_READ: begin
        ram_raddr = cnt;
      end
      S_RDOUT: begin
        done_next      = 1'b1;
        res_next       = '0;
        res_next.entry = ram_rdata;
      end
      default: begin
        rd_vld_next = 1'b0;
      end
    endcase

    if (done_next) res_next.threshold = worst_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      issue      <= 1'b0;
      rd_vld     <= 1'b0;
      dup_found  <= 1'b0;
      pos_found  <= 1'b0;
      clr_report <= 1'b0;
      worst      <= SENTINEL;
      tol        <= 16'd1;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      issue      <= issue_next;
      rd_vld     <= rd_vld_next;
      dup_found  <= dup_found_next;
      pos_found  <= pos_found_next;
      clr_report <= clr_report_next;
      worst      <= worst_next;
      done       <= done_next;
      if (cfg_valid && cfg_ready) tol <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx  <= rd_idx_next;
    pos     <= pos_next;
    score_l <= score_l_next;
    pay_l   <= pay_l_next;
    res     <= res_next;
  end

  assign accepted       = res.accepted;
  assign duplicate      = res.duplicate;
  assign rank           = res.rank;
  assign threshold      = res.threshold;
  assign entry_score    = res.entry.score;
  assign entry_ih       = res.entry.pay.ih;
  assign entry_na       = res.entry.pay.na;
  assign entry_start0   = res.entry.pay.start0;
  assign entry_start1   = res.entry.pay.start1;
  assign entry_start2   = res.entry.pay.start2;
  assign entry_reversed = res.entry.pay.reversed;
  assign entry_tag      = res.entry.pay.tag;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the top-k minimum list: shadow list, command driver, result monitor.
`timescale 1ns / 1ps

// How it works
//   An initial block queues commands phase by phase. The driver presents one command
//   at a time on falling edges. The monitor samples at rising edges. On each command
//   transfer (start high, busy low) the monitor runs the command through a shadow copy
//   of the list and queues the expected result. Each done strobe is checked field by
//   field against the oldest expected result.
//   Between phases the sender waits until every expected result has come back, then
//   writes a new dup_tolerance.
//   Reads are aimed only at ranks that hold written entries. A written entry always has
//   a score below the all-ones sentinel, so written entries fill ranks 0..filled-1.
//   The requested rank is folded into that range when the read is issued.
module tb;
  import tkml_pkg::*;

  localparam int         DEPTH      = 128;
  localparam logic [1:0] OP_NOP     = 2'd3;   // unused opcode, reports threshold only
  localparam int         IDLE_LIMIT = 2000;   // cycles with no transfer of any kind
  localparam int         RAND_ITEMS = 330;    // random commands per random phase
  localparam int         RECENT_MAX = 64;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] score;
    payload_t    pay;
    logic [6:0]  rank;
  } command_t;

  // ---------------------------------------------------------------- DUT ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = '0;
  logic [31:0] score = '0;
  logic [2:0]  ih_type = '0;
  logic [7:0]  na_count = '0;
  logic [7:0]  start0 = '0;
  logic [7:0]  start1 = '0;
  logic [7:0]  start2 = '0;
  logic        reversed = 1'b0;
  logic [15:0] payload_tag = '0;
  logic [6:0]  read_rank = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        done;
  logic        accepted;
  logic        duplicate;
  logic [6:0]  rank;
  logic [31:0] threshold;
  logic [31:0] entry_score;
  logic [2:0]  entry_ih;
  logic [7:0]  entry_na;
  logic [7:0]  entry_start0;
  logic [7:0]  entry_start1;
  logic [7:0]  entry_start2;
  logic        entry_reversed;
  logic [15:0] entry_tag;

  top_k_min_list_insert #(.TOP_ENTRIES(DEPTH)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .score         (score),
    .ih_type       (ih_type),
    .na_count      (na_count),
    .start0        (start0),
    .start1        (start1),
    .start2        (start2),
    .reversed      (reversed),
    .payload_tag   (payload_tag),
    .read_rank     (read_rank),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .done          (done),
    .accepted      (accepted),
    .duplicate     (duplicate),
    .rank          (rank),
    .threshold     (threshold),
    .entry_score   (entry_score),
    .entry_ih      (entry_ih),
    .entry_na      (entry_na),
    .entry_start0  (entry_start0),
    .entry_start1  (entry_start1),
    .entry_start2  (entry_start2),
    .entry_reversed(entry_reversed),
    .entry_tag     (entry_tag)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- shadow list
  logic [31:0] list_score [DEPTH];   // score by slot
  int          rank_slot  [DEPTH];   // slot held at each rank
  payload_t    slot_pay   [DEPTH];   // payload by slot
  logic [31:0] worst;                // score at the last rank
  logic [15:0] tol;                  // dup_tolerance as last written
  int          filled;               // written entries, always ranks 0..filled-1

  command_t    cmds_pending [$];     // filled by the stimulus, drained by the driver
  result_t     results_due  [$];     // expected results, oldest first
  command_t    on_port;              // command currently presented
  logic        took = 1'b0;          // transfer seen at the last rising edge
  int          gap_pct = 0;          // sender idle chance per cycle, in percent
  int          errors = 0;
  logic [31:0] recent_scores [$];    // seeds for near and equal scores

  function automatic void clear_list();
    int i;
    for (i = 0; i < DEPTH; i++) begin
      list_score[i] = SENTINEL;
      rank_slot[i]  = i;
      slot_pay[i]   = '0;
    end
    worst  = SENTINEL;
    filled = 0;
  endfunction

  // Applies one command to the shadow list and returns the result it must give.
  function automatic result_t apply_to_list(command_t c);
    result_t     r;
    logic [31:0] s;
    logic [31:0] d;
    logic        dup;
    int          i;
    int          pos;
    int          slot;
    r = '0;
    case (c.op)
      OP_INSERT: begin
        if (c.score < worst) begin
          dup = 1'b0;
          for (i = 0; i < DEPTH; i++) begin
            s = list_score[rank_slot[i]];
            d = (c.score > s) ? c.score - s : s - c.score;
            if (d < {16'd0, tol}) dup = 1'b1;
          end
          if (dup) begin
            r.duplicate = 1'b1;
          end else begin
            // first rank holding a strictly larger score; equal scores stay ahead
            pos = DEPTH - 1;
            for (i = DEPTH - 1; i >= 0; i--)
              if (c.score < list_score[rank_slot[i]]) pos = i;
            slot = rank_slot[DEPTH - 1];
            for (i = DEPTH - 1; i > pos; i--) rank_slot[i] = rank_slot[i - 1];
            rank_slot[pos]   = slot;
            list_score[slot] = c.score;
            slot_pay[slot]   = c.pay;
            worst            = list_score[rank_slot[DEPTH - 1]];
            if (filled < DEPTH) filled++;
            r.accepted = 1'b1;
            r.rank     = pos[6:0];
          end
        end
      end
      OP_READ: begin
        slot          = rank_slot[c.rank];
        r.entry.score = list_score[slot];
        r.entry.pay   = slot_pay[slot];
      end
      OP_CLEAR: clear_list();
      default: ;
    endcase
    r.threshold = worst;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  // A command stays on the port until its transfer; the next one may follow at once.
  always @(negedge clk) begin
    command_t c;
    logic     hold;
    hold = start && !took;
    if (!rst && !hold && cmds_pending.size() > 0 && $urandom_range(99) >= gap_pct) begin
      c = cmds_pending.pop_front();
      // aim reads at written ranks only; with an empty list the read becomes a no-op
      if (c.op == OP_READ) begin
        if (filled == 0) c.op = OP_NOP;
        else c.rank = 7'(c.rank % filled);
      end
      on_port     = c;
      opcode      <= c.op;
      score       <= c.score;
      ih_type     <= c.pay.ih;
      na_count    <= c.pay.na;
      start0      <= c.pay.start0;
      start1      <= c.pay.start1;
      start2      <= c.pay.start2;
      reversed    <= c.pay.reversed;
      payload_tag <= c.pay.tag;
      read_rank   <= c.rank;
      hold = 1'b1;
    end
    start <= hold;
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (done) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with none expected, threshold actual %0h", $time, threshold);
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(accepted));
          check_field("duplicate", 32'(want.duplicate), 32'(duplicate));
          check_field("rank", 32'(want.rank), 32'(rank));
          check_field("threshold", want.threshold, threshold);
          check_field("entry_score", want.entry.score, entry_score);
          check_field("entry_ih", 32'(want.entry.pay.ih), 32'(entry_ih));
          check_field("entry_na", 32'(want.entry.pay.na), 32'(entry_na));
          check_field("entry_start0", 32'(want.entry.pay.start0), 32'(entry_start0));
          check_field("entry_start1", 32'(want.entry.pay.start1), 32'(entry_start1));
          check_field("entry_start2", 32'(want.entry.pay.start2), 32'(entry_start2));
          check_field("entry_reversed", 32'(want.entry.pay.reversed),
                      32'(entry_reversed));
          check_field("entry_tag", 32'(want.entry.pay.tag), 32'(entry_tag));
        end
      end
      if (start && !busy) results_due.push_back(apply_to_list(on_port));
    end
  end

  // ---------------------------------------------------------------- watchdog
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, results_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic payload_t rand_payload();
    payload_t p;
    p.ih       = 3'($urandom_range(1, 6));
    p.na       = 8'($urandom_range(255));
    p.start0   = 8'($urandom_range(255));
    p.start1   = 8'($urandom_range(255));
    p.start2   = 8'($urandom_range(255));
    p.reversed = 1'($urandom_range(1));
    p.tag      = 16'($urandom_range(16'hFFFF));
    return p;
  endfunction

  task automatic push_cmd(logic [1:0] op, logic [31:0] s, logic [6:0] r, payload_t p);
    command_t c;
    c.op    = op;
    c.score = s;
    c.rank  = r;
    c.pay   = p;
    cmds_pending.push_back(c);
  endtask

  // Mostly a dense band so the list fills and the threshold falls, plus scores close
  // to or equal to earlier ones, wide random scores and the extremes.
  function automatic logic [31:0] rand_score();
    logic [31:0] s;
    logic [31:0] base;
    int          k;
    k = $urandom_range(99);
    if (recent_scores.size() > 0)
      base = recent_scores[$urandom_range(recent_scores.size() - 1)];
    else
      base = 32'($urandom_range(32'h00FF_FFFF));
    if (k < 55) s = 32'($urandom_range(32'h00FF_FFFF));
    else if (k < 70) s = base + 32'($urandom_range(2 * tol + 4)) - 32'(tol) - 32'd2;
    else if (k < 80) s = base;
    else if (k < 92) s = $urandom();
    else begin
      case ($urandom_range(3))
        0: s = 32'd0;
        1: s = 32'd1;
        2: s = SENTINEL - 32'd1;
        default: s = SENTINEL;
      endcase
    end
    recent_scores.push_back(s);
    if (recent_scores.size() > RECENT_MAX) void'(recent_scores.pop_front());
    return s;
  endfunction

  function automatic logic [1:0] rand_op();
    int k;
    k = $urandom_range(999);
    if (k < 650) return OP_INSERT;
    if (k < 960) return OP_READ;
    if (k < 995) return OP_NOP;
    return OP_CLEAR;
  endfunction

  // Sender holds off until every expected result has come back.
  task automatic drain();
    do @(posedge clk);
    while (busy || start || cmds_pending.size() != 0 || results_due.size() != 0);
  endtask

  task automatic write_tol(logic [15:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk);
    while (!cfg_ready);
    tol = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  int          phase;
  logic [15:0] phase_tol [6] = '{16'hFFFF, 16'd0, 16'd300, 16'd1, 16'd0, 16'd2};
  int          phase_gap [6] = '{0, 46, 23, 46, 0, 23};
  payload_t    pay_max;
  payload_t    pay_min;

  initial begin
    clear_list();
    tol = 16'd1;
    pay_max = '{tag: 16'hFFFF, reversed: 1'b1, start2: 8'hFF, start1: 8'hFF,
                start0: 8'hFF, na: 8'hFF, ih: 3'd6};
    pay_min = '{tag: 16'h0, reversed: 1'b0, start2: 8'h0, start1: 8'h0,
                start0: 8'h0, na: 8'h0, ih: 3'd1};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    drain();  // clearing pass after reset

    // Directed, reset tolerance of 1 (exact match only).
    push_cmd(OP_NOP, 32'd0, 7'd0, pay_min);           // threshold only
    push_cmd(OP_INSERT, SENTINEL, 7'd0, pay_max);     // not below threshold
    push_cmd(OP_INSERT, 32'd0, 7'd0, pay_max);
    push_cmd(OP_INSERT, 32'd0, 7'd0, pay_min);        // exact duplicate
    push_cmd(OP_INSERT, SENTINEL - 32'd1, 7'd0, pay_min);
    push_cmd(OP_INSERT, 32'd100, 7'd0, rand_payload());
    push_cmd(OP_INSERT, 32'd200, 7'd0, rand_payload());
    push_cmd(OP_INSERT, 32'd150, 7'd0, rand_payload());
    push_cmd(OP_INSERT, 32'd101, 7'd0, rand_payload()); // one apart: not a duplicate
    push_cmd(OP_READ, 32'd0, 7'd0, pay_min);
    push_cmd(OP_READ, 32'd0, 7'd127, pay_min);
    push_cmd(OP_READ, 32'd0, 7'd3, pay_min);
    drain();

    // Directed, zero tolerance: equal scores queue up behind stored ones.
    write_tol(16'd0);
    push_cmd(OP_INSERT, 32'd150, 7'd0, rand_payload());
    push_cmd(OP_INSERT, 32'd150, 7'd0, rand_payload());
    push_cmd(OP_INSERT, 32'd0, 7'd0, rand_payload());
    push_cmd(OP_INSERT, SENTINEL - 32'd1, 7'd0, rand_payload());
    push_cmd(OP_READ, 32'd0, 7'd0, pay_min);
    push_cmd(OP_READ, 32'd0, 7'd1, pay_min);
    push_cmd(OP_READ, 32'd0, 7'd4, pay_min);
    push_cmd(OP_READ, 32'd0, 7'd5, pay_min);
    push_cmd(OP_READ, 32'd0, 7'd9, pay_min);
    push_cmd(OP_CLEAR, 32'd0, 7'd0, pay_min);
    push_cmd(OP_NOP, 32'd0, 7'd0, pay_min);
    push_cmd(OP_INSERT, 32'd5, 7'd0, pay_max);
    push_cmd(OP_READ, 32'd0, 7'd0, pay_min);
    drain();

    // Random phases, each from an empty list under its own tolerance and pacing.
    for (phase = 0; phase < 6; phase++) begin
      write_tol(phase == 4 ? 16'($urandom_range(16'hFFFF)) : phase_tol[phase]);
      gap_pct = phase_gap[phase];
      recent_scores.delete();
      push_cmd(OP_CLEAR, 32'd0, 7'd0, pay_min);
      repeat (RAND_ITEMS)
        push_cmd(rand_op(), rand_score(), 7'($urandom_range(127)), rand_payload());
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tkml_pkg.sv
rtl/tkml_ram.sv
rtl/tkml_cmp.sv
rtl/top_k_min_list_insert.sv
tb/tb.sv
